// ===== design/atat_pkg.sv =====
// Package for the accelerometer tilt angle block: widths, register codes,
// the pipeline payload type and the elaboration-time sine threshold tables.
// Used by every module of the block; depends on nothing.
`default_nettype none

package atat_pkg;

	localparam int ACCEL_FRAC_BITS = 12;

	localparam int IN_W     = 16;
	localparam int EXT_W    = IN_W + 1;
	localparam int VAL_W    = ACCEL_FRAC_BITS + 1;
	localparam int IDX_W    = 10;
	localparam int IDX_N    = 1 << IDX_W;
	localparam int RES_W    = IDX_W + 1;
	localparam int ANGLE_W  = 13;
	localparam int BASE_W   = 12;
	localparam int FLAT_W   = 15;
	localparam int COS_W    = 13;
	localparam int CFG_W    = 15;
	localparam int SHIFT    = 30 - ACCEL_FRAC_BITS;
	localparam int SEARCH_STEPS = IDX_W - 1;

	localparam logic [EXT_W-1:0] ONE_EXT = EXT_W'(1) << ACCEL_FRAC_BITS;

	localparam int SIN_FULL  = 900;
	localparam int HALF_TURN = 1800;

	localparam logic [63:0] PI_Q30    = 64'd3373259426;
	localparam logic [63:0] ONE_Q30   = 64'd1073741824;
	localparam logic [63:0] FRAC_MASK = (64'd1 << SHIFT) - 64'd1;
	localparam logic [63:0] TAYLOR_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
		64'd110, 64'd156, 64'd210};

	localparam logic [FLAT_W-1:0] FLAT_LIMIT_RST = FLAT_W'(1229);
	localparam logic [COS_W-1:0]  COS_SWITCH_RST = COS_W'(2867);

	localparam logic CFG_FLAT_LIMIT = 1'b0;
	localparam logic CFG_COS_SWITCH = 1'b1;

	localparam logic [BASE_W-1:0] BASE_ASIN   = BASE_W'(0);
	localparam logic [BASE_W-1:0] BASE_ACOS   = BASE_W'(900);
	localparam logic [BASE_W-1:0] BASE_MIRROR = BASE_W'(1800);
	localparam logic [BASE_W-1:0] BASE_WRAP   = BASE_W'(2700);

	typedef enum logic {
		OP_ADD,
		OP_SUB
	} op_t;

	typedef struct packed {
		logic [FLAT_W-1:0] flat_limit;
		logic [COS_W-1:0]  cos_switch;
	} cfg_t;

	typedef struct packed {
		logic              flat;
		logic              use_floor;
		logic              key_zero;
		op_t               op;
		logic [BASE_W-1:0] base;
		logic [VAL_W-1:0]  key;
		logic [IDX_W-1:0]  r;
	} work_t;

	typedef logic [VAL_W-1:0] sin_tab_t [IDX_N];

	function automatic logic [63:0] sin_q30(input int a);
		logic [63:0] t;
		logic [63:0] t2;
		logic [63:0] term;
		longint      sum;
		if (a <= 0) return 64'd0;
		if (a >= SIN_FULL) return ONE_Q30;
		t = (64'(a) * PI_Q30) / 64'(HALF_TURN);
		t2 = (t * t) >> 30;
		term = t;
		sum = longint'(t);
		for (int k = 1; k <= 7; k++) begin
			term = ((term * t2) >> 30) / TAYLOR_DIV[k];
			if ((k & 1) != 0) sum = sum - longint'(term);
			else sum = sum + longint'(term);
		end
		if (sum < 0) sum = 0;
		if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
		return 64'(sum);
	endfunction

	function automatic sin_tab_t build_tab(input logic round_up);
		sin_tab_t    tab;
		logic [63:0] s;
		for (int i = 0; i < IDX_N; i++) begin
			if (i > SIN_FULL) begin
				tab[i] = '1;
			end else begin
				s = sin_q30(i);
				tab[i] = VAL_W'(s >> SHIFT);
				if (round_up && ((s & FRAC_MASK) != 64'd0)) tab[i] = tab[i] + VAL_W'(1);
			end
		end
		return tab;
	endfunction

	localparam sin_tab_t SIN_CEIL  = build_tab(1'b1);
	localparam sin_tab_t SIN_FLOOR = build_tab(1'b0);

	function automatic logic [VAL_W-1:0] clamp_mag(input logic [IN_W-1:0] v);
		logic [EXT_W-1:0] ext;
		logic [EXT_W-1:0] mag;
		ext = {v[IN_W-1], v};
		mag = v[IN_W-1] ? (~ext + EXT_W'(1)) : ext;
		if (mag > ONE_EXT) mag = ONE_EXT;
		return mag[VAL_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== design/atat_front.sv =====
// Input stage: clamps x and y, tests the flat limit and the asin threshold,
// and picks the search table, key, base and sign for each sample.
// Depends on atat_pkg.
`default_nettype none

module atat_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire atat_pkg::cfg_t              cfg,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [atat_pkg::IN_W-1:0]   accel_x,
	input  wire logic [atat_pkg::IN_W-1:0]   accel_y,
	input  wire logic [atat_pkg::IN_W-1:0]   accel_z,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output atat_pkg::work_t                  out_work
);

	logic                              valid_s1;
	atat_pkg::work_t                   work_s1;
	atat_pkg::work_t                   nxt;
	logic [atat_pkg::VAL_W-1:0]        mag_x;
	logic [atat_pkg::VAL_W-1:0]        mag_y;
	logic [atat_pkg::VAL_W-1:0]        m;
	logic [atat_pkg::EXT_W-1:0]        z_ext;
	logic [atat_pkg::EXT_W-1:0]        mag_z;
	logic                              x_neg;
	logic                              y_neg;
	logic                              use_asin;

	always_comb begin
		x_neg = accel_x[atat_pkg::IN_W-1];
		y_neg = accel_y[atat_pkg::IN_W-1];
		mag_x = atat_pkg::clamp_mag(accel_x);
		mag_y = atat_pkg::clamp_mag(accel_y);
		z_ext = {accel_z[atat_pkg::IN_W-1], accel_z};
		mag_z = accel_z[atat_pkg::IN_W-1] ? (~z_ext + atat_pkg::EXT_W'(1)) : z_ext;
		use_asin = atat_pkg::EXT_W'(mag_x) > atat_pkg::EXT_W'(cfg.cos_switch);
		nxt = '0;
		nxt.flat = mag_z >= atat_pkg::EXT_W'(cfg.flat_limit);
		if (use_asin) begin
			m = mag_y;
			if (!x_neg) begin
				nxt.base = atat_pkg::BASE_ASIN;
				nxt.op = y_neg ? atat_pkg::OP_SUB : atat_pkg::OP_ADD;
				nxt.use_floor = 1'b0;
			end else begin
				nxt.base = atat_pkg::BASE_MIRROR;
				nxt.op = y_neg ? atat_pkg::OP_ADD : atat_pkg::OP_SUB;
				nxt.use_floor = !y_neg;
			end
		end else begin
			m = mag_x;
			nxt.base = y_neg ? atat_pkg::BASE_WRAP : atat_pkg::BASE_ACOS;
			if (y_neg == x_neg) begin
				nxt.op = atat_pkg::OP_SUB;
				nxt.use_floor = 1'b1;
			end else begin
				nxt.op = atat_pkg::OP_ADD;
				nxt.use_floor = 1'b0;
			end
		end
		nxt.key_zero = (m == '0);
		nxt.key = nxt.use_floor ? (m - atat_pkg::VAL_W'(1)) : m;
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			work_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_work = work_s1;

endmodule

`default_nettype wire

// ===== design/atat_search.sv =====
// Pipelined bisection over the sine threshold tables, one index bit per stage;
// the last bit takes a lookup stage and a compare stage.
// Depends on atat_pkg.
`default_nettype none

module atat_search (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire atat_pkg::work_t in_work,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output atat_pkg::work_t      out_work
);

	logic [atat_pkg::SEARCH_STEPS-1:0] step_valid_s;
	atat_pkg::work_t             step_work_s [atat_pkg::SEARCH_STEPS];
	logic [atat_pkg::SEARCH_STEPS:0]   step_ready;
	logic [atat_pkg::SEARCH_STEPS:0]   link_valid;
	atat_pkg::work_t             link_work [atat_pkg::SEARCH_STEPS+1];

	logic                        lut_valid_s11;
	atat_pkg::work_t             lut_work_s11;
	logic [atat_pkg::VAL_W-1:0]  lut_lo_s11;
	logic [atat_pkg::VAL_W-1:0]  lut_hi_s11;
	logic                        ready_s11;
	logic [atat_pkg::IDX_W-1:0]  idx_lo;
	logic [atat_pkg::IDX_W-1:0]  idx_hi;
	logic [atat_pkg::VAL_W-1:0]  sel_lo;
	logic [atat_pkg::VAL_W-1:0]  sel_hi;

	logic                        cmp_valid_s12;
	atat_pkg::work_t             cmp_work_s12;
	logic                        ready_s12;
	logic [atat_pkg::VAL_W-1:0]  g_last;
	atat_pkg::work_t             cmp_nxt;

	assign link_valid[0] = in_valid;
	assign link_work[0] = in_work;
	assign in_ready = step_ready[0];

	for (genvar j = 0; j < atat_pkg::SEARCH_STEPS; j++) begin : g_step
		logic [atat_pkg::IDX_W-1:0] cand;
		logic [atat_pkg::VAL_W-1:0] g;
		atat_pkg::work_t            nxt;

		always_comb begin
			cand = link_work[j].r | (atat_pkg::IDX_W'(1) << (atat_pkg::IDX_W - 1 - j));
			g = link_work[j].use_floor ? atat_pkg::SIN_FLOOR[cand] : atat_pkg::SIN_CEIL[cand];
			nxt = link_work[j];
			if (g <= link_work[j].key) nxt.r = cand;
		end

		assign step_ready[j] = !step_valid_s[j] || step_ready[j+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				step_valid_s[j] <= 1'b0;
			end else if (step_ready[j]) begin
				step_valid_s[j] <= link_valid[j];
			end
		end

		always_ff @(posedge clk) begin
			if (step_ready[j] && link_valid[j]) begin
				step_work_s[j] <= nxt;
			end
		end

		assign link_valid[j+1] = step_valid_s[j];
		assign link_work[j+1] = step_work_s[j];
	end

	assign step_ready[atat_pkg::SEARCH_STEPS] = ready_s11;
	assign ready_s11 = !lut_valid_s11 || ready_s12;

	always_comb begin
		idx_lo = {1'b0, link_work[atat_pkg::SEARCH_STEPS].r[atat_pkg::IDX_W-2:1], 1'b1};
		idx_hi = {1'b1, link_work[atat_pkg::SEARCH_STEPS].r[atat_pkg::IDX_W-2:1], 1'b1};
		sel_lo = link_work[atat_pkg::SEARCH_STEPS].use_floor ? atat_pkg::SIN_FLOOR[idx_lo]
			: atat_pkg::SIN_CEIL[idx_lo];
		sel_hi = link_work[atat_pkg::SEARCH_STEPS].use_floor ? atat_pkg::SIN_FLOOR[idx_hi]
			: atat_pkg::SIN_CEIL[idx_hi];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lut_valid_s11 <= 1'b0;
		end else if (ready_s11) begin
			lut_valid_s11 <= link_valid[atat_pkg::SEARCH_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s11 && link_valid[atat_pkg::SEARCH_STEPS]) begin
			lut_work_s11 <= link_work[atat_pkg::SEARCH_STEPS];
			lut_lo_s11 <= sel_lo;
			lut_hi_s11 <= sel_hi;
		end
	end

	assign ready_s12 = !cmp_valid_s12 || out_ready;

	always_comb begin
		g_last = lut_work_s11.r[atat_pkg::IDX_W-1] ? lut_hi_s11 : lut_lo_s11;
		cmp_nxt = lut_work_s11;
		if (g_last <= lut_work_s11.key) cmp_nxt.r[0] = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_valid_s12 <= 1'b0;
		end else if (ready_s12) begin
			cmp_valid_s12 <= lut_valid_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s12 && lut_valid_s11) begin
			cmp_work_s12 <= cmp_nxt;
		end
	end

	assign out_valid = cmp_valid_s12;
	assign out_work = cmp_work_s12;

endmodule

`default_nettype wire

// ===== design/atat_back.sv =====
// Output stage: turns the search index into the mirrored angle, applies the
// flat override and holds the result in the output register.
// Depends on atat_pkg.
`default_nettype none

module atat_back (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire atat_pkg::work_t                in_work,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [atat_pkg::ANGLE_W-1:0]        angle_tenths,
	output logic                                forced_flat
);

	logic                          valid_s13;
	logic [atat_pkg::ANGLE_W-1:0]  angle_s13;
	logic                          flat_s13;
	logic [atat_pkg::RES_W-1:0]    res;
	logic [atat_pkg::ANGLE_W-1:0]  angle_nxt;

	always_comb begin
		if (!in_work.use_floor) begin
			res = atat_pkg::RES_W'(in_work.r);
		end else if (in_work.key_zero) begin
			res = '0;
		end else begin
			res = atat_pkg::RES_W'(in_work.r) + atat_pkg::RES_W'(1);
		end
		case (in_work.op)
			atat_pkg::OP_ADD: angle_nxt = atat_pkg::ANGLE_W'(in_work.base)
				+ atat_pkg::ANGLE_W'(res);
			atat_pkg::OP_SUB: angle_nxt = atat_pkg::ANGLE_W'(in_work.base)
				- atat_pkg::ANGLE_W'(res);
			default: angle_nxt = '0;
		endcase
		if (in_work.flat) angle_nxt = '0;
	end

	assign in_ready = !valid_s13 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s13 <= 1'b0;
		end else if (in_ready) begin
			valid_s13 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			angle_s13 <= angle_nxt;
			flat_s13 <= in_work.flat;
		end
	end

	assign out_valid = valid_s13;
	assign angle_tenths = angle_s13;
	assign forced_flat = flat_s13;

endmodule

`default_nettype wire

// ===== design/accel_tilt_angle_tenths_top.sv =====
// Top level of the accelerometer tilt angle block: configuration registers
// and the front, search and output pipeline stages.
// Depends on atat_pkg, atat_front, atat_search and atat_back.
//
// One sample (x, y, z in signed Q3.12 g) enters per transaction on the s_axis
// channel; one result (angle in tenths of a degree and the flat flag) leaves
// per transaction on the m_axis channel, in the same order.
// The cfg port writes flat_limit (index 0) and cos_switch (index 1) at any
// clock edge with cfg_we high; write only while no sample is in flight.
// From the input transaction to m_axis_tvalid a sample passes one front
// stage, nine bisection stages of one index bit each, a table lookup stage
// and a compare stage for the last bit, and the output register.
// Throughput is one sample per cycle while m_axis_tready is high; each stage holds one sample.
// When m_axis_tready is low the output register holds its result, and every
// stage keeps accepting until the stage after it is full, so s_axis_tready
// falls only once all 13 stages are occupied; nothing is lost or repeated.
// Reset clears every stage and loads flat_limit 1229 and cos_switch 2867.
`default_nettype none

module accel_tilt_angle_tenths_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	// accel_x [15:0], accel_y [31:16], accel_z [47:32]
	input  wire logic [47:0]                 s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	// angle_tenths [12:0], zeros [15:13]
	output logic [15:0]                      m_axis_tdata,
	// forced_flat [0]
	output logic [0:0]                       m_axis_tuser,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_index,
	input  wire logic [atat_pkg::CFG_W-1:0]  cfg_data
);

	logic [atat_pkg::FLAT_W-1:0]   flat_limit_q;
	logic [atat_pkg::COS_W-1:0]    cos_switch_q;
	atat_pkg::cfg_t                cfg;

	logic                          front_valid;
	logic                          front_ready;
	atat_pkg::work_t               front_work;
	logic                          srch_valid;
	logic                          srch_ready;
	atat_pkg::work_t               srch_work;
	logic [atat_pkg::ANGLE_W-1:0]  angle_tenths;
	logic                          forced_flat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flat_limit_q <= atat_pkg::FLAT_LIMIT_RST;
			cos_switch_q <= atat_pkg::COS_SWITCH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				atat_pkg::CFG_FLAT_LIMIT: flat_limit_q <= cfg_data[atat_pkg::FLAT_W-1:0];
				atat_pkg::CFG_COS_SWITCH: cos_switch_q <= cfg_data[atat_pkg::COS_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.flat_limit = flat_limit_q;
	assign cfg.cos_switch = cos_switch_q;

	atat_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.accel_x   (s_axis_tdata[15:0]),
		.accel_y   (s_axis_tdata[31:16]),
		.accel_z   (s_axis_tdata[47:32]),
		.out_valid (front_valid),
		.out_ready (front_ready),
		.out_work  (front_work)
	);

	atat_search u_search (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_work   (front_work),
		.out_valid (srch_valid),
		.out_ready (srch_ready),
		.out_work  (srch_work)
	);

	atat_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (srch_valid),
		.in_ready     (srch_ready),
		.in_work      (srch_work),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.angle_tenths (angle_tenths),
		.forced_flat  (forced_flat)
	);

	assign m_axis_tdata = {{(16 - atat_pkg::ANGLE_W){1'b0}}, angle_tenths};
	assign m_axis_tuser = forced_flat;

endmodule

`default_nettype wire

// ===== test/accel_tilt_angle_tenths_top_tb.sv =====
// Self-checking testbench for accel_tilt_angle_tenths_top: predicts each tilt angle and
// flat flag from the accepted samples and compares every result transaction in order.
// Depends on atat_pkg and the accel_tilt_angle_tenths_top design.
`default_nettype none

module accel_tilt_angle_tenths_top_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] PI_Q30      = 64'd3373259426;
	localparam longint      ONE_Q30     = 64'sd1073741824;
	localparam int          ONE_G       = 1 << atat_pkg::ACCEL_FRAC_BITS;
	localparam longint      Q30_SCALE   = 64'sd1 << (30 - atat_pkg::ACCEL_FRAC_BITS);
	localparam int          STALL_LIMIT = 5000;
	localparam int          HOLD_CYCLES = 80;
	localparam int          DRAIN       = 16;
	localparam int          PHASE_ITEMS = 250;

	typedef struct {
		logic signed [12:0] angle;
		logic               flat;
	} tilt_result_t;

	typedef enum {ASIN_RISE, ASIN_MIRROR, ACOS_FALL, ACOS_WRAP} search_t;

	class tilt_scoreboard;
		longint       sine_tab [0:900];
		int unsigned  flat_limit;
		int unsigned  cos_switch;
		tilt_result_t pending [$];
		int           errors;

		function new();
			logic [63:0] t;
			logic [63:0] t2;
			logic [63:0] term;
			longint      acc;
			flat_limit = 1229;
			cos_switch = 2867;
			errors = 0;
			for (int a = 0; a <= 900; a++) begin
				t = (64'(a) * PI_Q30) / 64'd1800;
				t2 = (t * t) >> 30;
				term = t;
				acc = longint'(t);
				for (int k = 1; k <= 7; k++) begin
					term = ((term * t2) >> 30) / 64'((2 * k) * (2 * k + 1));
					if (k % 2 == 1) acc = acc - longint'(term);
					else acc = acc + longint'(term);
				end
				if (acc < 0) acc = 0;
				if (acc > ONE_Q30) acc = ONE_Q30;
				sine_tab[a] = (a == 0) ? 0 : (a == 900) ? ONE_Q30 : acc;
			end
		endfunction

		function longint sin_at(int a);
			if (a < 0) return -sine_tab[-a];
			return sine_tab[a];
		endfunction

		function bit fits(search_t kind, int r, longint v);
			case (kind)
				ASIN_RISE:   return sin_at(r) <= v;
				ASIN_MIRROR: return v <= sin_at(1800 - r);
				ACOS_FALL:   return sin_at(900 - r) >= v;
				default:     return sin_at(r - 2700) <= v;
			endcase
		endfunction

		function int search(search_t kind, int lo, int hi, longint v);
			int mid;
			while (lo < hi) begin
				mid = lo + (hi - lo + 1) / 2;
				if (fits(kind, mid, v)) lo = mid;
				else hi = mid - 1;
			end
			return lo;
		endfunction

		function int clamp_g(int v);
			if (v > ONE_G) return ONE_G;
			if (v < -ONE_G) return -ONE_G;
			return v;
		endfunction

		function void note_sample(logic [47:0] data);
			int           x;
			int           y;
			int           z;
			int           angle;
			longint       xq;
			longint       yq;
			tilt_result_t r;
			x = clamp_g(int'($signed(data[15:0])));
			y = clamp_g(int'($signed(data[31:16])));
			z = int'($signed(data[47:32]));
			xq = longint'(x) * Q30_SCALE;
			yq = longint'(y) * Q30_SCALE;
			r.flat = 1'b0;
			if ((z < 0 ? -z : z) >= int'(flat_limit)) begin
				angle = 0;
				r.flat = 1'b1;
			end else if ((x < 0 ? -x : x) > int'(cos_switch)) begin
				if (x < 0) angle = search(ASIN_MIRROR, 900, 2700, yq);
				else if (y < 0) angle = -search(ASIN_RISE, 0, 900, -yq);
				else angle = search(ASIN_RISE, 0, 900, yq);
			end else begin
				if (y < 0) angle = search(ACOS_WRAP, 1800, 3600, xq);
				else angle = search(ACOS_FALL, 0, 1800, xq);
			end
			r.angle = 13'(angle);
			pending.push_back(r);
		endfunction

		function void check_result(logic [15:0] data, logic flat);
			tilt_result_t want;
			if (pending.size() == 0) begin
				$error("Result with no sample pending: angle_tenths %0d, forced_flat %0b",
					$signed(data[12:0]), flat);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (data[12:0] !== want.angle) begin
				$error("angle_tenths: expected %0d, actual %0d", want.angle, $signed(data[12:0]));
				errors++;
			end
			if (flat !== want.flat) begin
				$error("forced_flat: expected %0b, actual %0b", want.flat, flat);
				errors++;
			end
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       s_axis_tvalid;
	logic                       s_axis_tready;
	logic [47:0]                s_axis_tdata;
	logic                       m_axis_tvalid;
	logic                       m_axis_tready;
	logic [15:0]                m_axis_tdata;
	logic [0:0]                 m_axis_tuser;
	logic                       cfg_we;
	logic                       cfg_index;
	logic [atat_pkg::CFG_W-1:0] cfg_data;

	tilt_scoreboard sb;
	int             send_idle_pct = 17;
	int             recv_idle_pct = 81;
	bit             long_hold = 1'b0;

	accel_tilt_angle_tenths_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) sb.note_sample(s_axis_tdata);
		if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser[0]);
	end

	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold = 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !arst_n)
				quiet = 0;
			else
				quiet++;
		end
		$display("FAILURE");
		$finish;
	end

	function automatic int rand_axis(int unsigned cos);
		int v;
		int sgn;
		sgn = ($urandom_range(1) == 1) ? -1 : 1;
		case ($urandom_range(9))
			0, 1, 2, 3: v = int'($urandom_range(2 * ONE_G)) - ONE_G;
			4, 5: v = int'($urandom_range(65535)) - 32768;
			6: v = sgn * (int'(cos) + int'($urandom_range(4)) - 2);
			7: v = sgn * (ONE_G + int'($urandom_range(4)) - 2);
			8: v = sgn * int'($urandom_range(32));
			default: begin
				case ($urandom_range(3))
					0: v = -32768;
					1: v = 32767;
					2: v = 0;
					default: v = sgn * ONE_G;
				endcase
			end
		endcase
		return v;
	endfunction

	function automatic int rand_z(int unsigned flat);
		int v;
		int sgn;
		sgn = ($urandom_range(1) == 1) ? -1 : 1;
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: begin
				if (flat == 0) v = int'($urandom_range(65535));
				else v = int'($urandom_range(2 * flat - 2)) - (int'(flat) - 1);
			end
			6, 7: v = int'($urandom_range(65535));
			8: v = sgn * (int'(flat) + int'($urandom_range(2)) - 1);
			default: begin
				case ($urandom_range(2))
					0: v = -32768;
					1: v = 32767;
					default: v = 0;
				endcase
			end
		endcase
		return v;
	endfunction

	task automatic send_sample(input int x, input int y, input int z);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {16'(z), 16'(y), 16'(x)};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic run_phase(input int unsigned flat, input int unsigned cos,
			input int send_pct, input int recv_pct, input bit hold);
		cfg_we <= 1'b1;
		cfg_index <= atat_pkg::CFG_FLAT_LIMIT;
		cfg_data <= atat_pkg::CFG_W'(flat);
		@(posedge clk);
		cfg_index <= atat_pkg::CFG_COS_SWITCH;
		cfg_data <= atat_pkg::CFG_W'(cos);
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.flat_limit = flat & 32'h7FFF;
		sb.cos_switch = cos & 32'h1FFF;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		if (hold) long_hold = 1'b1;
		repeat (PHASE_ITEMS) send_sample(rand_axis(sb.cos_switch), rand_axis(sb.cos_switch),
			rand_z(sb.flat_limit));
		drain();
	endtask

	initial begin
		sb = new();
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = atat_pkg::CFG_FLAT_LIMIT;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Axis extremes, both sides of the switch threshold and the flat limit.
		send_sample(0, 0, 0);
		send_sample(4096, 0, 0);
		send_sample(-4096, 0, 0);
		send_sample(0, 4096, 0);
		send_sample(0, -4096, 0);
		send_sample(32767, 32767, 0);
		send_sample(-32768, -32768, 0);
		send_sample(4096, -4096, 0);
		send_sample(2867, 1000, 0);
		send_sample(2868, 1000, 0);
		send_sample(-2868, -1000, 0);
		send_sample(-2867, -1000, 0);
		send_sample(4096, 1, 0);
		send_sample(-4096, 1, 0);
		send_sample(-1, 0, 0);
		send_sample(1, -1, 0);
		send_sample(2896, 2896, 0);
		send_sample(-2000, -3000, 0);
		send_sample(0, 0, 1228);
		send_sample(0, 0, 1229);
		send_sample(0, 0, -1229);
		send_sample(0, 0, -32768);
		send_sample(0, 0, 32767);
		send_sample(-32768, 32767, -1228);
		drain();

		run_phase(1229, 2867, 17, 81, 1'b0);
		run_phase(32767, 2867, 17, 81, 1'b0);
		run_phase(32767, 0, 17, 81, 1'b0);
		run_phase(0, 4096, 81, 17, 1'b0);
		run_phase(32767, 4096, 81, 17, 1'b0);
		run_phase($urandom_range(32767), $urandom_range(4096), 81, 17, 1'b0);
		run_phase(32767, 8191, 0, 0, 1'b1);
		run_phase($urandom_range(32767), $urandom_range(4096), 0, 0, 1'b0);

		if (sb.errors == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
